// File: rtl/tslr_pkg.sv
`default_nettype none

package tslr_pkg;

  localparam int unsigned LINES_DEF    = 64;
  localparam int unsigned LINE_LEN_DEF = 128;

  localparam logic [6:0] VIEWPORT_RST = 7'd24;

  localparam logic [7:0] CH_NUL       = 8'd0;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  typedef enum logic [2:0] {
    CMD_APPEND      = 3'd0,
    CMD_SCROLL_UP   = 3'd1,
    CMD_SCROLL_DOWN = 3'd2,
    CMD_BOTTOM      = 3'd3,
    CMD_CLEAR       = 3'd4,
    CMD_READ        = 3'd5
  } tslr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NL,
    ST_READ
  } tslr_state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  char_in;
    logic [15:0] scroll_amount;
    logic [5:0]  read_line;
    logic [6:0]  read_column;
  } tslr_in_t;

  typedef struct packed {
    logic [6:0] lines_held;
    logic [6:0] rows_back;
    logic [5:0] view_start;
    logic [6:0] view_count;
    logic [7:0] read_char;
    logic [7:0] current_column;
  } tslr_out_t;

  typedef struct packed {
    logic char_we;
    logic len_we;
    logic rd_en;
  } tslr_mem_ctl_t;

  typedef struct packed {
    logic busy;
    logic res_load;
  } tslr_ctl_stat_t;

endpackage

`default_nettype wire

// File: rtl/tslr_store.sv
`default_nettype none

module tslr_store #(
  parameter int unsigned LINES    = tslr_pkg::LINES_DEF,
  parameter int unsigned LINE_LEN = tslr_pkg::LINE_LEN_DEF,
  localparam int unsigned SW  = $clog2(LINES),
  localparam int unsigned CW  = $clog2(LINE_LEN + 1),
  localparam int unsigned CAW = $clog2(LINES * LINE_LEN)
) (
  input  logic                    clk,
  input  tslr_pkg::tslr_mem_ctl_t ctl,
  input  logic [CAW-1:0]          char_waddr,
  input  logic [7:0]              char_wdata,
  input  logic [CAW-1:0]          char_raddr,
  output logic [7:0]              char_rdata,
  input  logic [SW-1:0]           len_waddr,
  input  logic [CW-1:0]           len_wdata,
  input  logic [SW-1:0]           len_raddr,
  output logic [CW-1:0]           len_rdata
);

  localparam int unsigned CHARS = LINES * LINE_LEN;

  logic [7:0]    char_mem [CHARS];
  logic [CW-1:0] len_mem  [LINES];

  always_ff @(posedge clk) begin
    if (ctl.char_we) begin
      char_mem[char_waddr] <= char_wdata;
    end
    if (ctl.rd_en) begin
      char_rdata <= char_mem[char_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (ctl.rd_en) begin
      len_rdata <= len_mem[len_raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tslr_ctrl.sv
`default_nettype none

module tslr_ctrl #(
  parameter int unsigned LINES    = tslr_pkg::LINES_DEF,
  parameter int unsigned LINE_LEN = tslr_pkg::LINE_LEN_DEF,
  localparam int unsigned SW  = $clog2(LINES),
  localparam int unsigned CW  = $clog2(LINE_LEN + 1),
  localparam int unsigned CAW = $clog2(LINES * LINE_LEN)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  tslr_pkg::tslr_in_t       in_data,
  input  logic                     out_free,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [6:0]               cfg_data,
  output tslr_pkg::tslr_ctl_stat_t stat,
  output tslr_pkg::tslr_out_t      res,
  output tslr_pkg::tslr_mem_ctl_t  mem_ctl,
  output logic [CAW-1:0]           char_waddr,
  output logic [7:0]               char_wdata,
  output logic [CAW-1:0]           char_raddr,
  input  logic [7:0]               char_rdata,
  output logic [SW-1:0]            len_waddr,
  output logic [CW-1:0]            len_wdata,
  output logic [SW-1:0]            len_raddr,
  input  logic [CW-1:0]            len_rdata
);

  import tslr_pkg::*;

  localparam int unsigned HW  = $clog2(LINES + 1);
  localparam int unsigned AW  = ((HW > 6) ? HW : 6) + 1;
  localparam int unsigned OW  = ((HW > 16) ? HW : 16) + 1;
  localparam int unsigned VW  = ((HW > 7) ? HW : 7) + 1;
  localparam int unsigned PW  = CAW + 8;
  localparam int unsigned CXW = (CW > 8) ? CW : 8;

  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                            input logic [AW-1:0] logical);
    logic [AW-1:0] s;
    s = AW'(base) + logical;
    if (s >= AW'(LINES)) begin
      s = s - AW'(LINES);
    end
    return s[SW-1:0];
  endfunction

  function automatic logic [CAW-1:0] char_addr(input logic [SW-1:0] slot,
                                               input logic [PW-1:0] col);
    logic [PW-1:0] a;
    a = PW'(slot) * PW'(LINE_LEN) + col;
    return a[CAW-1:0];
  endfunction

  tslr_state_t   state_r, state_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic [SW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] off_r, off_nxt;
  logic [6:0]    vp_r, vp_nxt;

  logic          rd_ok_r;
  logic [6:0]    rd_col_r;

  logic          acc;
  logic          is_read;
  logic          do_app;
  logic          first;
  logic [7:0]    ch_eff;
  logic          ch_nl, ch_ret, ch_bs;
  logic          need_nl, nl_first;
  logic [HW-1:0] h1, hn;
  logic [CW-1:0] col1, wc;
  logic [SW-1:0] on, last;
  logic [SW-1:0] rd_slot;
  logic [OW-1:0] up_sum;

  logic [VW-1:0]  hv, vv, ov, maxoff, start, cnt;
  logic [CXW-1:0] cx;
  logic [7:0]     rchar;

  assign acc     = in_valid && (state_r == ST_IDLE) && out_free;
  assign is_read = (in_data.cmd == CMD_READ);

  // Append path; the ST_NL state replays a newline on a one-line store
  always_comb begin
    do_app   = (state_r == ST_NL) ||
               (acc && (in_data.cmd == CMD_APPEND) && (in_data.char_in != CH_NUL));
    ch_eff   = (state_r == ST_NL) ? CH_NEWLINE : in_data.char_in;
    ch_nl    = (ch_eff == CH_NEWLINE);
    ch_ret   = (ch_eff == CH_RETURN);
    ch_bs    = (ch_eff == CH_BACKSPACE);
    first    = (held_r == '0);
    h1       = first ? HW'(1) : held_r;
    col1     = first ? '0 : col_r;
    need_nl  = do_app && ((ch_nl && !first) ||
               (!ch_nl && !ch_ret && !ch_bs && (col1 >= CW'(LINE_LEN))));
    nl_first = do_app && ch_nl && first;
    hn       = (need_nl && (h1 < HW'(LINES))) ? h1 + HW'(1) : h1;
    if (need_nl && (h1 == HW'(LINES))) begin
      on = (oldest_r == SW'(LINES - 1)) ? '0 : oldest_r + SW'(1);
    end else begin
      on = oldest_r;
    end
    last     = slot_of(on, AW'(hn) - AW'(1));
    wc       = need_nl ? '0 : col1;
    rd_slot  = slot_of(oldest_r, AW'(in_data.read_line));
    up_sum   = OW'(off_r) + OW'(in_data.scroll_amount);
  end

  always_comb begin
    held_nxt   = held_r;
    oldest_nxt = oldest_r;
    col_nxt    = col_r;
    off_nxt    = off_r;
    vp_nxt     = (cfg_valid && cfg_ready) ? cfg_data : vp_r;
    mem_ctl    = '0;
    len_waddr  = last;
    len_wdata  = '0;
    char_waddr = char_addr(last, PW'(wc));
    char_wdata = ch_eff;
    char_raddr = char_addr(rd_slot, PW'(in_data.read_column));
    len_raddr  = rd_slot;

    if (do_app) begin
      held_nxt   = hn;
      oldest_nxt = on;
      if (need_nl) begin
        off_nxt = '0;
      end
      if (ch_nl) begin
        col_nxt        = '0;
        mem_ctl.len_we = 1'b1;
      end else if (ch_ret) begin
        col_nxt        = '0;
        mem_ctl.len_we = first;
      end else if (ch_bs) begin
        if (col1 != '0) begin
          col_nxt        = col1 - CW'(1);
          len_wdata      = col1 - CW'(1);
          mem_ctl.len_we = 1'b1;
        end else begin
          col_nxt        = '0;
          mem_ctl.len_we = first;
        end
      end else begin
        col_nxt         = wc + CW'(1);
        len_wdata       = wc + CW'(1);
        mem_ctl.len_we  = 1'b1;
        mem_ctl.char_we = 1'b1;
      end
    end else if (acc) begin
      case (in_data.cmd)
        CMD_SCROLL_UP: begin
          if (in_data.scroll_amount != '0) begin
            if (up_sum > OW'(held_r)) begin
              off_nxt = first ? '0 : held_r - HW'(1);
            end else begin
              off_nxt = up_sum[HW-1:0];
            end
          end
        end
        CMD_SCROLL_DOWN: begin
          if (OW'(in_data.scroll_amount) >= OW'(off_r)) begin
            off_nxt = '0;
          end else begin
            off_nxt = off_r - in_data.scroll_amount[HW-1:0];
          end
        end
        CMD_BOTTOM: begin
          off_nxt = '0;
        end
        CMD_CLEAR: begin
          held_nxt   = '0;
          oldest_nxt = '0;
          col_nxt    = '0;
          off_nxt    = '0;
        end
        CMD_READ: begin
          mem_ctl.rd_en = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Status of the window, from the state after this transaction
  always_comb begin
    hv = VW'(held_nxt);
    vv = (vp_r == '0) ? VW'(1) : VW'(vp_r);
    ov = VW'(off_nxt);
    maxoff = hv - vv;
    if (hv <= vv) begin
      start = '0;
    end else if (maxoff > ov) begin
      start = maxoff - ov;
    end else begin
      start = '0;
    end
    cnt = hv - start;
    if (cnt > vv) begin
      cnt = vv;
    end
    cx = CXW'(col_nxt);
    if ((state_r == ST_READ) && rd_ok_r && (PW'(rd_col_r) < PW'(len_rdata))) begin
      rchar = char_rdata;
    end else begin
      rchar = '0;
    end
    res.lines_held     = hv[6:0];
    res.rows_back      = ov[6:0];
    res.view_start     = start[5:0];
    res.view_count     = cnt[6:0];
    res.read_char      = rchar;
    res.current_column = cx[7:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && nl_first) begin
          state_nxt = ST_NL;
        end else if (acc && is_read) begin
          state_nxt = ST_READ;
        end
      end
      ST_NL:   state_nxt = ST_IDLE;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    stat.busy     = (state_r != ST_IDLE);
    stat.res_load = (state_r == ST_NL) || (state_r == ST_READ) ||
                    (acc && !is_read && !nl_first);
    cfg_ready     = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      held_r   <= '0;
      oldest_r <= '0;
      col_r    <= '0;
      off_r    <= '0;
      vp_r     <= VIEWPORT_RST;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      oldest_r <= oldest_nxt;
      col_r    <= col_nxt;
      off_r    <= off_nxt;
      vp_r     <= vp_nxt;
    end
  end

  // Hold the range checks of a read until the memories answer
  always_ff @(posedge clk) begin
    if (acc && is_read) begin
      rd_ok_r  <= (AW'(in_data.read_line) < AW'(held_r)) &&
                  (PW'(in_data.read_column) < PW'(LINE_LEN));
      rd_col_r <= in_data.read_column;
    end
  end

`ifndef SYNTHESIS
  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HW'(LINES))
    else $error("line count beyond capacity");

  a_off_le_held: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= held_r)
    else $error("scroll offset beyond line count");

  a_col_max: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(LINE_LEN))
    else $error("write column beyond line length");

  a_nl_second: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NL) |-> (stat.res_load && (held_r == HW'(1))))
    else $error("second newline cycle without its single line or result");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (!acc && !mem_ctl.char_we))
    else $error("transaction taken or character written while busy");
`endif

endmodule

`default_nettype wire

// File: rtl/text_scrollback_line_ring.sv
`default_nettype none

// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   tslr_in_t  (cmd, char, scroll, read position)
// out_     output     out_valid / out_stall tslr_out_t (counts, window, read char, column)
// cfg_     input      cfg_valid / cfg_ready cfg_data   (visible rows of the window)
//
// Most transactions load their result when taken; the result sits in an output register.
// A read passes through ST_READ for the registered read of the line and character memories.
// A newline on an empty store writes the length of line 0 when taken and that of line 1 in ST_NL.
// Synchronous active-low reset clears the control state; the memories need no clearing pass.
// A new transaction is taken once the block is idle and the output register is empty or being drained.

module text_scrollback_line_ring #(
  parameter int unsigned LINES    = tslr_pkg::LINES_DEF,
  parameter int unsigned LINE_LEN = tslr_pkg::LINE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tslr_pkg::tslr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tslr_pkg::tslr_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  import tslr_pkg::*;

  localparam int unsigned SW  = $clog2(LINES);
  localparam int unsigned CW  = $clog2(LINE_LEN + 1);
  localparam int unsigned CAW = $clog2(LINES * LINE_LEN);

  tslr_ctl_stat_t stat;
  tslr_out_t      res;
  tslr_mem_ctl_t  mem_ctl;
  logic [CAW-1:0] char_waddr, char_raddr;
  logic [7:0]     char_wdata, char_rdata;
  logic [SW-1:0]  len_waddr, len_raddr;
  logic [CW-1:0]  len_wdata, len_rdata;

  logic           out_valid_r, out_valid_nxt;
  tslr_out_t      out_data_r;
  logic           out_free;

  assign out_free      = !out_valid_r || !out_stall;
  assign in_stall      = stat.busy || !out_free;
  assign out_valid_nxt = stat.res_load || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_load) begin
      out_data_r <= res;
    end
  end

  tslr_ctrl #(
    .LINES    (LINES),
    .LINE_LEN (LINE_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .out_free   (out_free),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .res        (res),
    .mem_ctl    (mem_ctl),
    .char_waddr (char_waddr),
    .char_wdata (char_wdata),
    .char_raddr (char_raddr),
    .char_rdata (char_rdata),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata),
    .len_raddr  (len_raddr),
    .len_rdata  (len_rdata)
  );

  tslr_store #(
    .LINES    (LINES),
    .LINE_LEN (LINE_LEN)
  ) u_store (
    .clk        (clk),
    .ctl        (mem_ctl),
    .char_waddr (char_waddr),
    .char_wdata (char_wdata),
    .char_raddr (char_raddr),
    .char_rdata (char_rdata),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata),
    .len_raddr  (len_raddr),
    .len_rdata  (len_rdata)
  );

endmodule

`default_nettype wire

// File: verif/text_scrollback_line_ring_tb.sv
`default_nettype none

module text_scrollback_line_ring_tb;
  import tslr_pkg::*;

  localparam int unsigned LINES            = LINES_DEF;
  localparam int unsigned LINE_LEN         = LINE_LEN_DEF;
  localparam logic [2:0]  CMD_SPARE_6      = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7      = 3'd7;
  localparam int unsigned HANG_LIMIT       = 3000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned MAX_SHOWN        = 10;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  tslr_in_t   in_data;
  logic       out_valid;
  logic       out_stall;
  tslr_out_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;

  text_scrollback_line_ring DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Scrollback state as the block should hold it
  logic [7:0]  sb_text [LINES*LINE_LEN];
  logic [7:0]  sb_len [LINES];
  int unsigned sb_oldest;
  int unsigned sb_held;
  int unsigned sb_col;
  int unsigned sb_back;
  int unsigned sb_rows;

  tslr_out_t   status_due [$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned rows_settings;
  int unsigned evictions;
  int unsigned wraps;
  int unsigned hang_count;
  bit          in_gaps_on;
  bit          out_stalls_on;
  bit          hold_long;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void scrollback_reset();
    for (int i = 0; i < LINES*LINE_LEN; i++) sb_text[i] = '0;
    for (int i = 0; i < LINES; i++) sb_len[i] = '0;
    sb_oldest = 0;
    sb_held   = 0;
    sb_col    = 0;
    sb_back   = 0;
    sb_rows   = VIEWPORT_RST;
  endfunction

  function automatic int unsigned slot_at(int unsigned logical);
    int unsigned s;
    s = sb_oldest + logical;
    if (s >= LINES) s -= LINES;
    return s;
  endfunction

  function automatic void open_line();
    if (sb_held < LINES) begin
      sb_held++;
    end else begin
      evictions++;
      sb_oldest = (sb_oldest + 1 >= LINES) ? 0 : sb_oldest + 1;
    end
    sb_len[slot_at(sb_held - 1)] = '0;
    sb_col  = 0;
    sb_back = 0;
  endfunction

  function automatic void put_byte(logic [7:0] c);
    int unsigned slot;
    if (c == CH_NUL) return;
    if (sb_held == 0) begin
      sb_held = 1;
      sb_len[slot_at(0)] = '0;
      sb_col = 0;
    end
    if (c == CH_NEWLINE) begin
      open_line();
      return;
    end
    if (c == CH_RETURN) begin
      sb_col = 0;
      return;
    end
    slot = slot_at(sb_held - 1);
    if (c == CH_BACKSPACE) begin
      if (sb_col > 0) begin
        sb_col--;
        sb_len[slot] = 8'(sb_col);
      end
      return;
    end
    // a full line wraps before the byte lands
    if (sb_col >= LINE_LEN) begin
      wraps++;
      open_line();
      slot = slot_at(sb_held - 1);
    end
    sb_text[slot*LINE_LEN + sb_col] = c;
    sb_col++;
    sb_len[slot] = 8'(sb_col);
  endfunction

  function automatic tslr_out_t scrollback_apply(tslr_in_t it);
    tslr_out_t   r;
    int unsigned rchar, vp, start, cnt, maxoff, slot;
    rchar = 0;
    case (it.cmd)
      CMD_APPEND: put_byte(it.char_in);
      CMD_SCROLL_UP: begin
        if (it.scroll_amount != 0) begin
          if (sb_back + it.scroll_amount > sb_held)
            sb_back = (sb_held > 0) ? sb_held - 1 : 0;
          else sb_back += it.scroll_amount;
        end
      end
      CMD_SCROLL_DOWN: begin
        if (it.scroll_amount >= sb_back) sb_back = 0;
        else sb_back -= it.scroll_amount;
      end
      CMD_BOTTOM: sb_back = 0;
      CMD_CLEAR: begin
        sb_held   = 0;
        sb_oldest = 0;
        sb_col    = 0;
        sb_back   = 0;
      end
      CMD_READ: begin
        if (it.read_line < sb_held) begin
          slot = slot_at(it.read_line);
          if (it.read_column < sb_len[slot]) rchar = sb_text[slot*LINE_LEN + it.read_column];
        end
      end
      default: ;
    endcase
    vp = (sb_rows == 0) ? 1 : sb_rows;
    if (sb_held <= vp) begin
      start = 0;
    end else begin
      maxoff = sb_held - vp;
      start  = (maxoff > sb_back) ? maxoff - sb_back : 0;
    end
    cnt = sb_held - start;
    if (cnt > vp) cnt = vp;
    r.lines_held     = 7'(sb_held);
    r.rows_back      = 7'(sb_back);
    r.view_start     = 6'(start);
    r.view_count     = 7'(cnt);
    r.read_char      = 8'(rchar);
    r.current_column = 8'(sb_col);
    return r;
  endfunction

  function automatic tslr_in_t mk_item(logic [2:0] cmd, logic [7:0] ch, logic [15:0] amt,
                                       logic [5:0] ln, logic [6:0] cl);
    tslr_in_t it;
    it.cmd           = cmd;
    it.char_in       = ch;
    it.scroll_amount = amt;
    it.read_line     = ln;
    it.read_column   = cl;
    return it;
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [15:0] scroll_step();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 8));
    if (r < 9) return 16'($urandom_range(0, 80));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Mostly appends and well-aimed reads; the unused fields carry random noise.
  function automatic tslr_in_t random_traffic_item();
    tslr_in_t    it;
    int unsigned pick, slot;
    it = mk_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)),
                 7'($urandom_range(0, 127)));
    pick = $urandom_range(0, 999);
    if (pick < 470) begin
      it.cmd     = CMD_APPEND;
      it.char_in = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : printable();
    end else if (pick < 570) begin
      it.cmd     = CMD_APPEND;
      it.char_in = CH_NEWLINE;
    end else if (pick < 610) begin
      it.cmd     = CMD_APPEND;
      it.char_in = CH_RETURN;
    end else if (pick < 650) begin
      it.cmd     = CMD_APPEND;
      it.char_in = CH_BACKSPACE;
    end else if (pick < 660) begin
      it.cmd     = CMD_APPEND;
      it.char_in = CH_NUL;
    end else if (pick < 730) begin
      it.cmd           = CMD_SCROLL_UP;
      it.scroll_amount = scroll_step();
    end else if (pick < 790) begin
      it.cmd           = CMD_SCROLL_DOWN;
      it.scroll_amount = scroll_step();
    end else if (pick < 810) begin
      it.cmd = CMD_BOTTOM;
    end else if (pick < 965) begin
      it.cmd = CMD_READ;
      if (sb_held != 0 && $urandom_range(0, 9) != 0) begin
        it.read_line = 6'($urandom_range(0, sb_held - 1));
        slot = slot_at(it.read_line);
        if ($urandom_range(0, 3) != 0)
          it.read_column = 7'($urandom_range(0, (sb_len[slot] > 127) ? 127 : sb_len[slot]));
      end
    end else if (pick < 968) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
    return it;
  endfunction

  task automatic send_item(input tslr_in_t item);
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_due.push_back(scrollback_apply(item));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(mk_item(CMD_APPEND, c, '0, '0, '0));
  endtask

  task automatic send_read(input logic [5:0] ln, input logic [6:0] cl);
    send_item(mk_item(CMD_READ, '0, '0, ln, cl));
  endtask

  // Drop valid and wait for every outstanding status to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_rows(input logic [6:0] rows);
    cfg_valid <= 1'b1;
    cfg_data  <= rows;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb_rows = rows;
    rows_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed_cases();
    send_item(mk_item(CMD_BOTTOM, '0, '0, '0, '0));
    send_item(mk_item(CMD_SCROLL_UP, '0, 16'd0, '0, '0));
    send_item(mk_item(CMD_SCROLL_UP, '0, 16'hFFFF, '0, '0));
    send_item(mk_item(CMD_SCROLL_DOWN, '0, 16'hFFFF, '0, '0));
    send_read(6'd0, 7'd0);
    send_item(mk_item(CMD_SPARE_6, 8'hFF, 16'hFFFF, 6'h3F, 7'h7F));
    send_item(mk_item(CMD_SPARE_7, '0, '0, '0, '0));
    send_char(CH_NUL);
    send_item(mk_item(CMD_CLEAR, '0, '0, '0, '0));
    // backspace on an empty store still opens line 0
    send_char(CH_BACKSPACE);
    send_item(mk_item(CMD_CLEAR, '0, '0, '0, '0));
    send_char(CH_NEWLINE);
    send_char(8'hFF);
    send_char(8'h41);
    send_char(8'h01);
    send_char(CH_RETURN);
    send_char(8'h42);
    send_char(CH_BACKSPACE);
    send_char(CH_BACKSPACE);
    send_char(8'h7F);
    send_read(6'd1, 7'd0);
    send_read(6'd63, 7'd127);
    send_read(6'd1, 7'd127);
    send_item(mk_item(CMD_SCROLL_UP, '0, 16'd1, '0, '0));
    send_item(mk_item(CMD_SCROLL_UP, '0, 16'd5, '0, '0));
    send_item(mk_item(CMD_SCROLL_DOWN, '0, 16'd1, '0, '0));
  endtask

  task automatic test_line_wrap();
    send_item(mk_item(CMD_CLEAR, '0, '0, '0, '0));
    for (int i = 0; i < 2*LINE_LEN + 5; i++) send_char(printable());
    send_read(6'd0, 7'd127);
    send_read(6'd1, 7'd0);
    send_read(6'd2, 7'd4);
    send_read(6'd2, 7'd5);
    send_char(CH_BACKSPACE);
    send_read(6'd2, 7'd4);
  endtask

  // Push past the ring depth so the oldest lines fall out
  task automatic test_ring_eviction();
    for (int i = 0; i < LINES + 6; i++) begin
      for (int k = $urandom_range(0, 4); k > 0; k--) send_char(8'(8'h30 + (i % 64)));
      send_char(CH_NEWLINE);
    end
    send_read(6'd0, 7'd0);
    send_read(6'd62, 7'd0);
    send_read(6'd63, 7'd0);
    send_item(mk_item(CMD_SCROLL_UP, '0, 16'hFFFF, '0, '0));
    send_item(mk_item(CMD_SCROLL_DOWN, '0, 16'd3, '0, '0));
  endtask

  task automatic test_viewport_sweep();
    int unsigned rows_list [6];
    rows_list = '{1, 64, 0, 127, 24, 0};
    for (int k = 0; k < 6; k++) begin
      drain_results();
      write_rows(7'((k == 5) ? $urandom_range(2, 63) : rows_list[k]));
      for (int i = 0; i < 60; i++) send_item(random_traffic_item());
      send_item(mk_item(CMD_SCROLL_UP, '0, 16'd200, '0, '0));
    end
    drain_results();
  endtask

  task automatic test_output_hold();
    hold_long = 1'b1;
    for (int i = 0; i < 40; i++) send_item(random_traffic_item());
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit with_idling);
    if (!with_idling) begin
      in_gaps_on    = 1'b0;
      out_stalls_on = 1'b0;
    end
    for (int unsigned i = 0; i < count; i++) begin
      // alternate busy and quiet stretches
      if (with_idling && i % 64 == 0) begin
        in_gaps_on    = ($urandom_range(0, 3) != 0);
        out_stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_item(random_traffic_item());
    end
  endtask

  task automatic note_mismatch(input string what, input tslr_out_t want, input tslr_out_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("status mismatch (%s)", what);
      $display("  want held=%0d back=%0d start=%0d vis=%0d ch=%02h col=%0d",
               want.lines_held, want.rows_back, want.view_start, want.view_count,
               want.read_char, want.current_column);
      $display("  got  held=%0d back=%0d start=%0d vis=%0d ch=%02h col=%0d",
               got.lines_held, got.rows_back, got.view_start, got.view_count,
               got.read_char, got.current_column);
    end
  endtask

  // Receiver side: random hold-offs plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : check_results
    tslr_out_t want;
    string     bad;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (status_due.size() == 0) begin
          note_mismatch("no transaction outstanding", '0, out_data);
        end else begin
          want = status_due.pop_front();
          bad  = "";
          if (out_data.lines_held !== want.lines_held) bad = {bad, " lines_held"};
          if (out_data.rows_back !== want.rows_back) bad = {bad, " rows_back"};
          if (out_data.view_start !== want.view_start) bad = {bad, " view_start"};
          if (out_data.view_count !== want.view_count) bad = {bad, " view_count"};
          if (out_data.read_char !== want.read_char) bad = {bad, " read_char"};
          if (out_data.current_column !== want.current_column) bad = {bad, " current_column"};
          if (bad != "") note_mismatch(bad, want, out_data);
        end
      end
    end
  end

  initial begin : watchdog
    hang_count = 0;
    while (hang_count < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        hang_count = 0;
      else
        hang_count++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             HANG_LIMIT, status_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    hold_long     = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    results_seen  = 0;
    rows_settings = 0;
    evictions     = 0;
    wraps         = 0;
    scrollback_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_line_wrap();
    test_ring_eviction();
    test_viewport_sweep();
    test_output_hold();
    test_random_traffic(250, 1'b1);
    test_random_traffic(100, 1'b0);
    drain_results();
    repeat (8) @(negedge clk);

    if (status_due.size() != 0) begin
      $display("%0d expected status results never arrived", status_due.size());
      mismatches += status_due.size();
    end
    $display("Sent %0d transactions, checked %0d status results over %0d viewport settings",
             items_sent, results_seen, rows_settings);
    $display("Ring evicted %0d lines and wrapped %0d full lines; %0d mismatches",
             evictions, wraps, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
